>>> src/hsl_pkg.sv
package hsl_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] amount;
  } hsl_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } hsl_out_t;

  localparam logic CMD_LIGHTEN = 1'b0;
  localparam logic CMD_DARKEN  = 1'b1;

  // divisor width shared by the hue and saturation dividers (12*chroma fits)
  localparam int DIV_DB = 12;

  typedef enum logic [1:0] {
    SEG_RAMP = 2'd0,
    SEG_Q    = 2'd1,
    SEG_P    = 2'd2
  } seg_sel_t;

endpackage

>>> src/hsl_div.sv
module hsl_div #(
  parameter int QB = 17,
  parameter int DB = 12
) (
  input  logic               clk,
  input  logic               en,
  input  logic [DB+QB-1:0]   x,
  input  logic [DB-1:0]      y,
  output logic [QB-1:0]      quo
);

  localparam int RW = DB + QB;

  // one quotient bit per stage, msb first
  logic [RW-1:0] rem_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic [DB-1:0] y_r   [QB-1];

  logic [RW-1:0] rin_w [QB];
  logic [QB-1:0] qin_w [QB];
  logic [DB-1:0] yin_w [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int K = QB - 1 - j;
    logic [RW-1:0] ysh;
    logic          ge;

    if (j == 0) begin : g_first
      assign rin_w[j] = x;
      assign qin_w[j] = '0;
      assign yin_w[j] = y;
    end else begin : g_rest
      assign rin_w[j] = rem_r[j-1];
      assign qin_w[j] = quo_r[j-1];
      assign yin_w[j] = y_r[j-1];
    end

    assign ysh = RW'(yin_w[j]) << K;
    assign ge  = (rin_w[j] >= ysh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? (rin_w[j] - ysh) : rin_w[j];
        quo_r[j] <= qin_w[j] | (ge ? (QB'(1) << K) : '0);
      end
    end

    if (j < QB - 1) begin : g_ypipe
      always_ff @(posedge clk) begin
        if (en) begin
          y_r[j] <= yin_w[j];
        end
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

>>> src/hsl_lightness_adjust.sv
// HSL lightness adjust, one RGBA pixel per transfer.
// Input channel: in_valid / in_stall / in_data (cmd, red, green, blue, alpha,
// amount). cmd selects lighten or darken; amount shifts lightness in 1/255
// steps and the result is clamped, so large amounts give white or black.
// Output channel: out_valid / out_stall / out_data with the adjusted bytes
// and alpha copied unchanged.
// The pipeline has one input stage, then HUE_FRAC_BITS + 1 stages of the
// restoring dividers that form hue and saturation (one quotient bit per
// stage), with lightness taken from a reciprocal multiply and delayed to
// match, then six stages for the hsl to rgb multiplies, rounding and the
// output register. Throughput is one pixel per clock unless the output
// stalls; the divider stages set the depth.
// When the receiver stalls while a result is shown, the whole pipeline
// holds and in_stall is raised in the same cycle; nothing is lost or
// repeated. Reset (rst_n low, synchronous) clears every valid bit, so the
// pipeline comes up empty; no clearing sweep is needed.
module hsl_lightness_adjust #(
  parameter int HUE_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hsl_pkg::hsl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hsl_pkg::hsl_out_t out_data
);
  import hsl_pkg::*;

  localparam int F  = HUE_FRAC_BITS;
  localparam int QB = F + 1;
  localparam int XW = DIV_DB + QB;
  localparam int VW = F + 2;
  localparam int PW = 2 * QB + 1;
  localparam int PD = VW + 3 + QB;
  localparam int BW = VW + 9;
  localparam int ZW = F + 7;
  localparam int MW = F + 8;
  localparam int LPW = ZW + MW;

  localparam longint ONE_L = longint'(1) << F;
  localparam logic [QB-1:0] ONE   = QB'(ONE_L);
  localparam logic [QB-1:0] HALF  = QB'(ONE_L / 2);
  localparam logic [QB-1:0] THIRD = QB'((ONE_L + 1) / 3);
  localparam logic [QB-1:0] SIXTH = QB'((ONE_L + 3) / 6);
  localparam logic [QB-1:0] TWO3  = QB'((2 * ONE_L + 1) / 3);
  // ceil(2^(F+15) / 255), exact floor(z / 255) for z below 2^(F+7)
  localparam longint LMUL_L = ((longint'(1) << (F + 15)) + 254) / 255;
  localparam logic [MW-1:0] LMUL = MW'(LMUL_L);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- stage a: min/max, divider operands
  logic [7:0]  mx, mn, c, d;
  logic [8:0]  sum, amt2, lsum;
  logic [9:0]  lsum_up;
  logic [11:0] num;
  logic [1:0]  la;
  logic [7:0]  lb;

  always_comb begin
    mx = (in_data.red > in_data.green) ? in_data.red : in_data.green;
    if (in_data.blue > mx) mx = in_data.blue;
    mn = (in_data.red < in_data.green) ? in_data.red : in_data.green;
    if (in_data.blue < mn) mn = in_data.blue;
    c    = mx - mn;
    sum  = 9'(mx) + 9'(mn);
    amt2 = {in_data.amount, 1'b0};
    lsum_up = 10'(sum) + 10'(amt2);
    if (in_data.cmd == CMD_DARKEN) begin
      lsum = (sum < amt2) ? 9'd0 : (sum - amt2);
    end else begin
      lsum = (lsum_up > 10'd510) ? 9'd510 : lsum_up[8:0];
    end
    // lsum = 255*la + lb, so l = la*HALF + round(lb*HALF/255)
    if (lsum == 9'd510) begin
      la = 2'd2;
      lb = 8'd0;
    end else if (lsum >= 9'd255) begin
      la = 2'd1;
      lb = 8'(lsum - 9'd255);
    end else begin
      la = 2'd0;
      lb = lsum[7:0];
    end
    d = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
    // hue numerator, below 6*chroma whenever chroma is nonzero
    if (mx == in_data.red) begin
      num = (in_data.green >= in_data.blue) ? 12'(in_data.green - in_data.blue)
          : 12'(12'(c) * 12'd6 - 12'(in_data.blue - in_data.green));
    end else if (mx == in_data.green) begin
      num = 12'(c) * 12'd2 + 12'(in_data.blue) - 12'(in_data.red);
    end else begin
      num = 12'(c) * 12'd4 + 12'(in_data.red) - 12'(in_data.green);
    end
  end

  logic [XW-1:0]     xs_r, xh_r;
  logic [DIV_DB-1:0] ys_r, yh_r;
  logic [ZW-1:0]     lz_a_r;
  logic [1:0]        la_a_r;
  logic              gray_a_r, vld_a_r;
  logic [7:0]        alpha_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
    end
  end

  // round(n/m) computed as floor((2n + m) / 2m)
  always_ff @(posedge clk) begin
    if (en) begin
      xs_r      <= (XW'(c) << (F + 1)) + XW'(d);
      ys_r      <= DIV_DB'(d) << 1;
      xh_r      <= (XW'(num) << (F + 1)) + XW'(c) * XW'(6);
      yh_r      <= DIV_DB'(c) * DIV_DB'(12);
      lz_a_r    <= (ZW'(lb) << (F - 1)) + ZW'(127);
      la_a_r    <= la;
      gray_a_r  <= (c == 8'd0);
      alpha_a_r <= in_data.alpha;
    end
  end

  // ---------------- divider stages
  logic [QB-1:0] s_q, h_q, l_q;

  hsl_div #(.QB(QB), .DB(DIV_DB)) u_div_s (
    .clk(clk), .en(en), .x(xs_r), .y(ys_r), .quo(s_q)
  );
  hsl_div #(.QB(QB), .DB(DIV_DB)) u_div_h (
    .clk(clk), .en(en), .x(xh_r), .y(yh_r), .quo(h_q)
  );

  // lightness: reciprocal multiply, then delayed to line up with the dividers
  logic [LPW-1:0] lprod_r;
  logic [1:0]     la_1_r;
  logic [QB-1:0]  l_w;
  logic [QB-1:0]  l_p_r [QB-1];

  assign l_w = (QB'(la_1_r) << (F - 1)) + QB'(lprod_r >> (F + 15));

  always_ff @(posedge clk) begin
    if (en) begin
      lprod_r <= LPW'(lz_a_r) * LPW'(LMUL);
      la_1_r  <= la_a_r;
      l_p_r[0] <= l_w;
      for (int i = 1; i < QB - 1; i++) l_p_r[i] <= l_p_r[i-1];
    end
  end

  assign l_q = l_p_r[QB-2];

  logic       vld_p_r   [QB];
  logic       gray_p_r  [QB];
  logic [7:0] alpha_p_r [QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QB; i++) vld_p_r[i] <= 1'b0;
    end else if (en) begin
      vld_p_r[0] <= vld_a_r;
      for (int i = 1; i < QB; i++) vld_p_r[i] <= vld_p_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray_p_r[0]  <= gray_a_r;
      alpha_p_r[0] <= alpha_a_r;
      for (int i = 1; i < QB; i++) begin
        gray_p_r[i]  <= gray_p_r[i-1];
        alpha_p_r[i] <= alpha_p_r[i-1];
      end
    end
  end

  // ---------------- stage b: l * (1+s) or l * s
  logic [QB:0]   mop;
  logic          lt;
  logic [PW-1:0] prod_b_r;
  logic [QB-1:0] l_b_r, s_b_r, h_b_r;
  logic          lt_b_r, gray_b_r, vld_b_r;
  logic [7:0]    alpha_b_r;

  assign lt  = (l_q < HALF);
  assign mop = lt ? ({1'b0, ONE} + {1'b0, s_q}) : {1'b0, s_q};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_b_r  <= PW'(l_q) * PW'(mop);
      l_b_r     <= l_q;
      s_b_r     <= s_q;
      h_b_r     <= h_q;
      lt_b_r    <= lt;
      gray_b_r  <= gray_p_r[QB-1];
      alpha_b_r <= alpha_p_r[QB-1];
    end
  end

  // ---------------- stage c: p, q and hue offsets
  logic [PW-1:0] rnd_b;
  logic [VW-1:0] q_c, p_c, l2;
  logic [QB:0]   tr_w, tb_w;
  logic [QB-1:0] t_c [3];

  always_comb begin
    rnd_b = (prod_b_r + (PW'(1) << (F - 1))) >> F;
    if (lt_b_r) begin
      q_c = VW'(rnd_b);
    end else begin
      q_c = VW'(l_b_r) + VW'(s_b_r) - VW'(rnd_b);
    end
    l2  = VW'(l_b_r) << 1;
    p_c = (l2 < q_c) ? '0 : (l2 - q_c);
    if (q_c < p_c) q_c = p_c;
    tr_w = {1'b0, h_b_r} + {1'b0, THIRD};
    if (tr_w > {1'b0, ONE}) tr_w = tr_w - {1'b0, ONE};
    tb_w = (h_b_r < THIRD) ? ({1'b0, h_b_r} + {1'b0, ONE} - {1'b0, THIRD})
                           : ({1'b0, h_b_r} - {1'b0, THIRD});
    t_c[0] = tr_w[QB-1:0];
    t_c[1] = h_b_r;
    t_c[2] = tb_w[QB-1:0];
  end

  logic [VW-1:0] p_c_r, q_c_r;
  logic [QB-1:0] t_c_r [3];
  logic [QB-1:0] l_c_r;
  logic          gray_c_r, vld_c_r;
  logic [7:0]    alpha_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_c_r     <= p_c;
      q_c_r     <= q_c;
      for (int k = 0; k < 3; k++) t_c_r[k] <= t_c[k];
      l_c_r     <= l_b_r;
      gray_c_r  <= gray_b_r;
      alpha_c_r <= alpha_b_r;
    end
  end

  // ---------------- stage d: segment select and ramp multiply
  logic [VW+2:0] diff6;
  logic [QB-1:0] m_d [3];
  seg_sel_t      sel_d [3];

  always_comb begin
    diff6 = (VW+3)'(q_c_r - p_c_r) * (VW+3)'(6);
    for (int k = 0; k < 3; k++) begin
      if (t_c_r[k] < SIXTH) begin
        sel_d[k] = SEG_RAMP;
        m_d[k]   = t_c_r[k];
      end else if (t_c_r[k] < HALF) begin
        sel_d[k] = SEG_Q;
        m_d[k]   = '0;
      end else if (t_c_r[k] < TWO3) begin
        sel_d[k] = SEG_RAMP;
        m_d[k]   = TWO3 - t_c_r[k];
      end else begin
        sel_d[k] = SEG_P;
        m_d[k]   = '0;
      end
    end
  end

  logic [PD-1:0] prod_d_r [3];
  seg_sel_t      sel_d_r  [3];
  logic [VW-1:0] p_d_r, q_d_r;
  logic [QB-1:0] l_d_r;
  logic          gray_d_r, vld_d_r;
  logic [7:0]    alpha_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod_d_r[k] <= PD'(diff6) * PD'(m_d[k]);
        sel_d_r[k]  <= sel_d[k];
      end
      p_d_r     <= p_c_r;
      q_d_r     <= q_c_r;
      l_d_r     <= l_c_r;
      gray_d_r  <= gray_c_r;
      alpha_d_r <= alpha_c_r;
    end
  end

  // ---------------- stage e: channel value in fixed point
  logic [PD-1:0] rnd_d [3];
  logic [VW:0]   v_e   [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd_d[k] = (prod_d_r[k] + (PD'(1) << (F - 1))) >> F;
      if (gray_d_r) begin
        v_e[k] = (VW+1)'(l_d_r);
      end else begin
        case (sel_d_r[k])
          SEG_RAMP: v_e[k] = (VW+1)'(p_d_r) + rnd_d[k][VW:0];
          SEG_Q:    v_e[k] = (VW+1)'(q_d_r);
          default:  v_e[k] = (VW+1)'(p_d_r);
        endcase
      end
    end
  end

  logic [VW:0] v_e_r [3];
  logic        vld_e_r, gray_e_r;
  logic [7:0]  alpha_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) v_e_r[k] <= v_e[k];
      gray_e_r  <= gray_d_r;
      alpha_e_r <= alpha_d_r;
    end
  end

  // ---------------- stage f: scale to byte range
  logic [BW-1:0] b_f_r [3];
  logic          vld_f_r;
  logic [7:0]    alpha_f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) b_f_r[k] <= BW'(v_e_r[k]) * BW'(255);
      alpha_f_r <= alpha_e_r;
    end
  end

  // ---------------- output register: round and saturate
  logic [BW-1:0] rb   [3];
  logic [7:0]    byte_w [3];
  hsl_out_t      out_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rb[k]     = (b_f_r[k] + (BW'(1) << (F - 1))) >> F;
      byte_w[k] = (rb[k] > BW'(255)) ? 8'd255 : rb[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.red_out   <= byte_w[0];
      out_r.green_out <= byte_w[1];
      out_r.blue_out  <= byte_w[2];
      out_r.alpha_out <= alpha_f_r;
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r     <= 1'b0;
      vld_c_r     <= 1'b0;
      vld_d_r     <= 1'b0;
      vld_e_r     <= 1'b0;
      vld_f_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_b_r     <= vld_p_r[QB-1];
      vld_c_r     <= vld_b_r;
      vld_d_r     <= vld_c_r;
      vld_e_r     <= vld_d_r;
      vld_f_r     <= vld_e_r;
      out_valid_r <= vld_f_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- assertions
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_f_r && en) |=> out_valid)
    else $error("result lost between last stage and output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_r) && $stable(vld_f_r)))
    else $error("pipeline moved while output stalled");

  a_pq_order: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c_r |-> (q_c_r >= p_c_r))
    else $error("q below p");

  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_e_r && gray_e_r) |-> ((v_e_r[0] == v_e_r[1]) && (v_e_r[1] == v_e_r[2])))
    else $error("gray pixel channels differ");

endmodule
